### rtl/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg: shared types and constants of the terminal escape / mouse parser
// Phase codes, event kinds, byte codes and the event word carried between
// the parser core and the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tem_pkg;

	// parser phase; unused codes behave as idle
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ESC  = 3'd1,
		PH_CSI  = 3'd2,
		PH_BTN  = 3'd3,
		PH_COL  = 3'd4,
		PH_ROW  = 3'd5
	} phase_t;

	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_ESC   = 2'd1;
	localparam logic [1:0] KIND_MOUSE = 2'd2;

	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
	localparam logic [7:0] CH_LT     = 8'h3C; // '<'
	localparam logic [7:0] CH_0      = 8'd48;
	localparam logic [7:0] CH_9      = 8'd57;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_D      = 8'h44;

	localparam int          VAL_W   = 14;
	localparam logic [13:0] VAL_MAX = 14'd16383;

	typedef struct packed {
		logic [7:0]  mouse_status;
		logic [13:0] mouse_button;
		logic [14:0] mouse_y;
		logic [14:0] mouse_x;
		logic [7:0]  key_code;
		logic [1:0]  event_kind;
	} evt_t;

endpackage

`default_nettype wire

### rtl/tem_parse_core.sv
// ----------------------------------------------------------------------------
// tem_parse_core: byte parser state machine
// Holds the parse state, decodes one byte per accepted word and produces at
// most one event word for it, in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_parse_core #(
	parameter int MAX_DIGITS = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,      // byte accepted this cycle
	input  wire logic [7:0]    in_byte,
	output logic               evt_valid, // event produced by this byte
	output tem_pkg::evt_t      evt
);

	tem_pkg::phase_t phase_q, phase_d;
	logic [2:0]  digit_count_q, digit_count_d;
	logic [13:0] field_value_q, field_value_d;
	logic [13:0] saved_button_q, saved_button_d;
	logic [13:0] saved_column_q, saved_column_d;

	logic        is_digit;
	logic [17:0] prod;
	logic [13:0] acc;
	logic [2:0]  cnt_inc;
	logic        field_done;
	logic [13:0] fin_val;
	logic [7:0]  term;

	// decimal accumulate with saturation
	assign is_digit   = (in_byte >= tem_pkg::CH_0) && (in_byte <= tem_pkg::CH_9);
	assign prod       = {4'd0, field_value_q} * 18'd10 + {14'd0, in_byte[3:0]};
	assign acc        = (prod > {4'd0, tem_pkg::VAL_MAX}) ? tem_pkg::VAL_MAX : prod[13:0];
	assign cnt_inc    = digit_count_q + 3'd1;
	assign field_done = !is_digit || (cnt_inc >= 3'(MAX_DIGITS));
	assign fin_val    = is_digit ? acc : field_value_q;
	assign term       = is_digit ? 8'd0 : in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= tem_pkg::PH_IDLE;
			digit_count_q  <= 3'd0;
			field_value_q  <= 14'd0;
			saved_button_q <= 14'd0;
			saved_column_q <= 14'd0;
		end else if (take) begin
			phase_q        <= phase_d;
			digit_count_q  <= digit_count_d;
			field_value_q  <= field_value_d;
			saved_button_q <= saved_button_d;
			saved_column_q <= saved_column_d;
		end
	end

	always_comb begin
		phase_d        = tem_pkg::PH_IDLE;
		digit_count_d  = digit_count_q;
		field_value_d  = field_value_q;
		saved_button_d = saved_button_q;
		saved_column_d = saved_column_q;
		evt_valid      = 1'b0;
		evt            = '0;

		unique case (phase_q)
			tem_pkg::PH_ESC: begin
				phase_d = (in_byte == tem_pkg::CH_LBRACK) ? tem_pkg::PH_CSI
				                                          : tem_pkg::PH_IDLE;
			end
			tem_pkg::PH_CSI: begin
				if (in_byte == tem_pkg::CH_LT) begin
					phase_d       = tem_pkg::PH_BTN;
					digit_count_d = 3'd0;
					field_value_d = 14'd0;
				end else if (in_byte >= tem_pkg::CH_A && in_byte <= tem_pkg::CH_D) begin
					evt_valid      = 1'b1;
					evt.event_kind = tem_pkg::KIND_ESC;
					evt.key_code   = in_byte;
				end
			end
			tem_pkg::PH_BTN, tem_pkg::PH_COL, tem_pkg::PH_ROW: begin
				if (!field_done) begin
					phase_d       = phase_q;
					field_value_d = acc;
					digit_count_d = cnt_inc;
				end else begin
					digit_count_d = 3'd0;
					field_value_d = 14'd0;
					if (phase_q == tem_pkg::PH_BTN) begin
						saved_button_d = fin_val;
						phase_d        = tem_pkg::PH_COL;
					end else if (phase_q == tem_pkg::PH_COL) begin
						saved_column_d = fin_val;
						phase_d        = tem_pkg::PH_ROW;
					end else begin
						evt_valid        = 1'b1;
						evt.event_kind   = tem_pkg::KIND_MOUSE;
						evt.mouse_x      = {1'b0, saved_column_q} - 15'd1;
						evt.mouse_y      = {1'b0, fin_val} - 15'd1;
						evt.mouse_button = saved_button_q;
						evt.mouse_status = term;
					end
				end
			end
			default: begin
				if (in_byte == tem_pkg::CH_ESC) begin
					phase_d = tem_pkg::PH_ESC;
				end else begin
					evt_valid      = 1'b1;
					evt.event_kind = tem_pkg::KIND_KEY;
					evt.key_code   = in_byte;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/tem_out_buf.sv
// ----------------------------------------------------------------------------
// tem_out_buf: output register with skid stage
// Registers event words towards the master side; the skid entry holds one
// word pushed while the consumer stalls, after which ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,      // new word, only while ready
	input  wire tem_pkg::evt_t push_evt,
	output logic               ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tem_pkg::evt_t      out_evt
);

	logic          out_valid_q, skid_valid_q;
	tem_pkg::evt_t out_q, skid_q;
	logic          load_out;

	assign ready     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_evt   = out_q;
	assign load_out  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : push_evt;
		end else if (push) begin
			skid_q <= push_evt;
		end
	end

endmodule

`default_nettype wire

### rtl/terminal_escape_mouse_parser.sv
// ----------------------------------------------------------------------------
// terminal_escape_mouse_parser: terminal key, CSI arrow and SGR mouse decoder
// Each event word reaches the master side from the output register; it waits in the skid entry on a stall.
// Throughput: one byte per cycle while s_axis_tready is high; the parse state updates in the accept cycle.
// The slave side stalls only while both the output and skid words are full.
// Reset (arst_n low, asynchronous): idle phase, fields cleared, no words held.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_escape_mouse_parser #(
	parameter int MAX_DIGITS = 4 // digits per decimal field, 1 to 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte stream in
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	// event stream out
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // [7:0] key_code, [22:8] mouse_x,
	                                        // [37:23] mouse_y, [51:38] mouse_button,
	                                        // [59:52] mouse_status, [63:60] zero
	output logic [1:0]       m_axis_tuser   // [1:0] event_kind
);

	logic          take;
	logic          evt_valid;
	tem_pkg::evt_t evt;
	tem_pkg::evt_t out_evt;

	// a word is taken whenever the skid entry is free; the core always keeps up
	assign take = s_axis_tvalid && s_axis_tready;

	tem_parse_core #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (s_axis_tdata),
		.evt_valid (evt_valid),
		.evt       (evt)
	);

	// only bytes that finish an event push a word
	tem_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && evt_valid),
		.push_evt  (evt),
		.ready     (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_evt   (out_evt)
	);

	assign m_axis_tuser = out_evt.event_kind;
	assign m_axis_tdata = {4'd0, out_evt.mouse_status, out_evt.mouse_button,
	                       out_evt.mouse_y, out_evt.mouse_x, out_evt.key_code};

endmodule

`default_nettype wire
